>>> rtl/pbpd_pkg.sv
// Shared types and constants of the planar block predictive pixel decoder.
// Used by the top level, the front and the back; no dependencies.
`timescale 1ns / 1ps

package pbpd_pkg;

	localparam int CFG_DATA_W   = 12;
	localparam int COORD_W      = 12;
	localparam int OUT_COORD_W  = 11;
	localparam int CHAN_W       = 2;

	localparam logic [CFG_DATA_W-1:0] HEIGHT_LIMIT = 12'd2048;
	localparam logic [CHAN_W-1:0]     CHAN_FIRST   = 2'd2;
	localparam logic [CHAN_W-1:0]     CHAN_LAST    = 2'd0;

	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	// Position inside a 2x2 block, in stream order.
	typedef enum logic [1:0] {
		POS_TL = 2'd0,
		POS_BL = 2'd1,
		POS_TR = 2'd2,
		POS_BR = 2'd3
	} pos_t;

	typedef enum logic [1:0] {
		PRED_RAW  = 2'd0,
		PRED_LEFT = 2'd1,
		PRED_UP   = 2'd2,
		PRED_AVG  = 2'd3
	} pred_mode_t;

	typedef struct packed {
		logic [7:0]             raw;
		pos_t                   pos;
		pred_mode_t             mode;
		logic [CHAN_W-1:0]      channel;
		logic [COORD_W-1:0]     px;
		logic [OUT_COORD_W-1:0] py;
		logic                   last;
	} work_item_t;

	typedef struct packed {
		logic [7:0]             value;
		logic [CHAN_W-1:0]      channel;
		logic [OUT_COORD_W-1:0] px;
		logic [OUT_COORD_W-1:0] py;
		logic                   last;
	} result_t;

	localparam int ITEM_W   = $bits(work_item_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

>>> rtl/planar_block_predictive_pixel_decoder.sv
// Top level of the planar block predictive pixel decoder: front, work queue,
// back and result queue. Depends on pbpd_pkg, pbpd_front, pbpd_queue, pbpd_back.
//
//   channel   signals                                   direction
//   input     push, full, raw_byte                      in (queue write side)
//   result    pop, empty, sample_value, channel,        out (queue read side)
//             pixel_x, pixel_y, last_sample
//   config    cfg_write, cfg_index, cfg_data            in (write only)
//
// One byte is taken per cycle unless full, one sample delivered per cycle unless empty.
// A sample passes through the work queue, then the back stage with its line buffer
// read, and then the result queue before it reaches the result ports.
// Reset clears the position to plane 2, pixel (0,0) and both sizes to 1;
// the line buffer is not cleared, as no unwritten entry it returns is ever used.
// A stalled result side fills the result queue, then the back stage, then the
// work queue, and only then raises full.
`timescale 1ns / 1ps

module planar_block_predictive_pixel_decoder import pbpd_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             raw_byte,
	input  logic                   pop,
	output logic                   empty,
	output logic [7:0]             sample_value,
	output logic [CHAN_W-1:0]      channel,
	output logic [OUT_COORD_W-1:0] pixel_x,
	output logic [OUT_COORD_W-1:0] pixel_y,
	output logic                   last_sample
);

	localparam int WORK_DEPTH   = 4;
	localparam int RESULT_DEPTH = 2;

	logic              accept;
	logic              item_valid;
	work_item_t        item;
	logic              work_full;
	logic              work_empty;
	logic [ITEM_W-1:0] work_rd_data;
	work_item_t        head;
	logic              head_pop;
	logic              res_full;
	logic              res_push;
	result_t           res;
	logic [RESULT_W-1:0] res_rd_data;
	result_t           res_out;

	assign accept = push & ~work_full;
	assign full   = work_full;

	pbpd_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.raw_byte   (raw_byte),
		.item_valid (item_valid),
		.item       (item)
	);

	pbpd_queue #(
		.DATA_W (ITEM_W),
		.DEPTH  (WORK_DEPTH)
	) u_work_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (item_valid),
		.wr_data (item),
		.rd_en   (head_pop),
		.rd_data (work_rd_data),
		.full    (work_full),
		.empty   (work_empty)
	);

	assign head = work_item_t'(work_rd_data);

	pbpd_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_empty (work_empty),
		.head       (head),
		.head_pop   (head_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	pbpd_queue #(
		.DATA_W (RESULT_W),
		.DEPTH  (RESULT_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (res_rd_data),
		.full    (res_full),
		.empty   (empty)
	);

	assign res_out      = result_t'(res_rd_data);
	assign sample_value = res_out.value;
	assign channel      = res_out.channel;
	assign pixel_x      = res_out.px;
	assign pixel_y      = res_out.py;
	assign last_sample  = res_out.last;

	// The image only completes in the last plane.
	a_last_in_last_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_sample) |-> (channel == CHAN_LAST))
		else $error("last sample flagged outside the final plane");

	// Plane index counts down from two and wraps, never reaching three.
	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (channel != 2'd3))
		else $error("result carries an impossible channel");

	// The work queue only drains when the back stage has room for the item.
	a_back_takes_head: assert property (@(posedge clk) disable iff (!arst_n)
		(head_pop && res_full) |=> !work_full)
		else $error("work queue full right after a pop");

endmodule

>>> rtl/pbpd_queue.sv
// Small first-in first-out queue of register storage.
// Generic over data width and depth; no package dependencies.
`timescale 1ns / 1ps

module pbpd_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              full,
	output logic              empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/pbpd_front.sv
// Front part: size registers, stream position counters and classification
// of each byte into a pad or a work item. Depends on pbpd_pkg.
`timescale 1ns / 1ps

module pbpd_front import pbpd_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [7:0]            raw_byte,
	output logic                  item_valid,
	output work_item_t            item
);

	localparam int CmpW = COORD_W + 1;

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [COORD_W-1:0]    block_col_q;
	logic [COORD_W-1:0]    row_pair_q;
	pos_t                  pos_q;
	logic [CHAN_W-1:0]     plane_q;

	logic [CFG_DATA_W-1:0] width_eff;
	logic [CFG_DATA_W-1:0] height_eff;
	logic [CmpW-1:0]       px_ext;
	logic [CmpW-1:0]       py_ext;
	logic [CmpW-1:0]       col_next;
	logic [CmpW-1:0]       row_next;
	logic [CmpW-1:0]       w_ext;
	logic [CmpW-1:0]       h_ext;
	logic                  col_r_ok;
	logic                  row_b_ok;
	logic                  later_valid;
	logic                  in_image;

	// Sizes are saturated once, when written.
	always_comb begin
		if (cfg_data == '0) begin
			width_eff = CFG_DATA_W'(1);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			width_eff = CFG_DATA_W'(MAX_WIDTH);
		end else begin
			width_eff = cfg_data;
		end
		if (cfg_data == '0) begin
			height_eff = CFG_DATA_W'(1);
		end else if (cfg_data > HEIGHT_LIMIT) begin
			height_eff = HEIGHT_LIMIT;
		end else begin
			height_eff = cfg_data;
		end
	end

	assign w_ext    = CmpW'(width_q);
	assign h_ext    = CmpW'(height_q);
	assign px_ext   = CmpW'(block_col_q) + CmpW'(pos_q[1]);
	assign py_ext   = CmpW'(row_pair_q) + CmpW'(pos_q[0]);
	assign col_next = CmpW'(block_col_q) + CmpW'(2);
	assign row_next = CmpW'(row_pair_q) + CmpW'(2);
	assign col_r_ok = (CmpW'(block_col_q) + CmpW'(1)) < w_ext;
	assign row_b_ok = (CmpW'(row_pair_q) + CmpW'(1)) < h_ext;
	assign in_image = (px_ext < w_ext) && (py_ext < h_ext);

	// The final sample is the last non-pad byte of the final block of plane 0.
	always_comb begin
		case (pos_q)
			POS_TL:  later_valid = row_b_ok | col_r_ok;
			POS_BL:  later_valid = col_r_ok;
			POS_TR:  later_valid = col_r_ok & row_b_ok;
			default: later_valid = 1'b0;
		endcase
	end

	always_comb begin
		item.raw     = raw_byte;
		item.pos     = pos_q;
		item.channel = plane_q;
		item.px      = px_ext[COORD_W-1:0];
		item.py      = py_ext[OUT_COORD_W-1:0];
		item.last    = (plane_q == CHAN_LAST) && (col_next >= w_ext)
			&& (row_next >= h_ext) && !later_valid;
		if (px_ext == '0 && py_ext == '0) begin
			item.mode = PRED_RAW;
		end else if (py_ext == '0) begin
			item.mode = PRED_LEFT;
		end else if (px_ext == '0) begin
			item.mode = PRED_UP;
		end else begin
			item.mode = PRED_AVG;
		end
	end

	// Pad bytes are consumed here and never reach the back part.
	assign item_valid = accept & in_image;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CFG_DATA_W'(1);
			height_q    <= CFG_DATA_W'(1);
			block_col_q <= '0;
			row_pair_q  <= '0;
			pos_q       <= POS_TL;
			plane_q     <= CHAN_FIRST;
		end else if (cfg_write) begin
			if (cfg_reg_t'(cfg_index) == CFG_WIDTH) begin
				width_q <= width_eff;
			end else begin
				height_q <= height_eff;
			end
			block_col_q <= '0;
			row_pair_q  <= '0;
			pos_q       <= POS_TL;
			plane_q     <= CHAN_FIRST;
		end else if (accept) begin
			pos_q <= pos_t'(pos_q + 2'd1);
			if (pos_q == POS_BR) begin
				if (col_next >= w_ext) begin
					block_col_q <= '0;
					if (row_next >= h_ext) begin
						row_pair_q <= '0;
						plane_q    <= (plane_q == CHAN_LAST) ? CHAN_FIRST : plane_q - 1'b1;
					end else begin
						row_pair_q <= row_next[COORD_W-1:0];
					end
				end else begin
					block_col_q <= col_next[COORD_W-1:0];
				end
			end
		end
	end

endmodule

>>> rtl/pbpd_back.sv
// Back part: line buffer of the previous row pair, neighbour registers and
// the prediction arithmetic. Depends on pbpd_pkg.
`timescale 1ns / 1ps

module pbpd_back import pbpd_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_empty,
	input  work_item_t head,
	output logic       head_pop,
	input  logic       res_full,
	output logic       res_push,
	output result_t    res
);

	localparam int AddrW = $clog2(MAX_WIDTH);

	logic [7:0]       line_mem [MAX_WIDTH];
	logic             valid_s2;
	work_item_t       item_s2;
	logic [7:0]       up_rd_s2;
	logic             fwd_s2;
	logic [7:0]       fwd_val_s2;

	logic [7:0]       left_top_q;
	logic [7:0]       left_bottom_q;
	logic [7:0]       block_top_q;

	logic             fire;
	logic             load;
	logic             fwd_hit;
	logic [AddrW-1:0] rd_addr;
	logic [AddrW-1:0] wr_addr;
	logic [7:0]       up_line;
	logic [7:0]       up_val;
	logic [7:0]       left_val;
	logic [8:0]       pair_sum;
	logic [7:0]       value;

	assign fire     = valid_s2 & ~res_full;
	assign load     = ~head_empty & (~valid_s2 | fire);
	assign head_pop = load;
	assign rd_addr  = AddrW'({{AddrW{1'b0}}, head.px});
	assign wr_addr  = AddrW'({{AddrW{1'b0}}, item_s2.px});

	// Top positions take "up" from the line buffer, read as the item enters
	// the stage; the entry was written by the bottom row of the previous pair.
	always_ff @(posedge clk) begin
		if (load && !head.pos[0]) begin
			up_rd_s2 <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s2.pos[0]) begin
			line_mem[wr_addr] <= value;
		end
	end

	// With a width of one, the top pixel of a new row pair reads the entry that
	// the bottom pixel in the stage is writing at the same edge, so the new value
	// is taken straight from the stage.
	assign fwd_hit = fire & item_s2.pos[0] & (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (load && !head.pos[0]) begin
			fwd_s2     <= fwd_hit;
			fwd_val_s2 <= value;
		end
	end

	assign up_line = fwd_s2 ? fwd_val_s2 : up_rd_s2;

	always_comb begin
		case (item_s2.pos)
			POS_TL: begin
				up_val   = up_line;
				left_val = left_top_q;
			end
			POS_BL: begin
				up_val   = block_top_q;
				left_val = left_bottom_q;
			end
			POS_TR: begin
				up_val   = up_line;
				left_val = block_top_q;
			end
			default: begin
				up_val   = left_top_q;
				left_val = left_bottom_q;
			end
		endcase
		pair_sum = {1'b0, up_val} + {1'b0, left_val};
		case (item_s2.mode)
			PRED_RAW:  value = item_s2.raw;
			PRED_LEFT: value = left_val - item_s2.raw;
			PRED_UP:   value = up_val - item_s2.raw;
			default:   value = pair_sum[8:1] - item_s2.raw;
		endcase
	end

	assign res_push    = fire;
	assign res.value   = value;
	assign res.channel = item_s2.channel;
	assign res.px      = item_s2.px[OUT_COORD_W-1:0];
	assign res.py      = item_s2.py;
	assign res.last    = item_s2.last;

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			left_top_q    <= '0;
			left_bottom_q <= '0;
			block_top_q   <= '0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				case (item_s2.pos)
					POS_TL:  block_top_q   <= value;
					POS_TR:  left_top_q    <= value;
					default: left_bottom_q <= value;
				endcase
			end
		end
	end

endmodule
